>>> hdl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define MCL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// checked property that also holds during reset
`define MCL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MCL_ASSERT(lbl, clk, rst, prop)
`define MCL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hdl/mclc_pkg.sv
// constants, tables and helpers of the current limit codec
package mclc_pkg;

  typedef enum logic [1:0] {
    OP_DECODE  = 2'd0,
    OP_ENCODE  = 2'd1,
    OP_MEASURE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam int unsigned CFG_PRODUCT = 0;
  localparam int unsigned CFG_OFFSET  = 1;
  localparam int unsigned CFG_SCALE   = 2;

  localparam logic [15:0] BASE_OFFSET = 16'd800;
  localparam logic [15:0] BASE_SCALE  = 16'd1875;
  localparam logic [16:0] DECODE_DUTY = 17'd600;
  localparam logic [6:0]  MAX_CODE    = 7'd95;
  localparam logic [6:0]  END_RANGE0  = 7'd31;
  localparam logic [6:0]  END_RANGE1  = 7'd63;
  localparam int unsigned DVD_W       = 34;
  localparam int unsigned DVS_W       = 18;

  localparam logic [15:0] VILIM_ROM [4][32] = '{
    '{16'd0, 16'd809, 16'd1528, 16'd2178, 16'd2776, 16'd3335, 16'd3865, 16'd4374,
      16'd4868, 16'd5352, 16'd5833, 16'd6314, 16'd6799, 16'd7292, 16'd7797, 16'd8319,
      16'd8861, 16'd9428, 16'd10025, 16'd10658, 16'd11331, 16'd12054, 16'd12833,
      16'd13679, 16'd14604, 16'd15623, 16'd16752, 16'd18014, 16'd19437, 16'd21058,
      16'd22923, 16'd25097},
    '{16'd0, 16'd1353, 16'd2592, 16'd3742, 16'd4821, 16'd5845, 16'd6826, 16'd7776,
      16'd8703, 16'd9615, 16'd10519, 16'd11423, 16'd12333, 16'd13254, 16'd14192,
      16'd15154, 16'd16146, 16'd17175, 16'd18247, 16'd19371, 16'd20555, 16'd21809,
      16'd23143, 16'd24572, 16'd26109, 16'd27772, 16'd29583, 16'd31566, 16'd33752,
      16'd36179, 16'd38894, 16'd41958},
    '{16'd0, 16'd935, 16'd1791, 16'd2585, 16'd3330, 16'd4037, 16'd4715, 16'd5371,
      16'd6011, 16'd6641, 16'd7265, 16'd7890, 16'd8518, 16'd9154, 16'd9802, 16'd10466,
      16'd11152, 16'd11862, 16'd12603, 16'd13379, 16'd14197, 16'd15063, 16'd15985,
      16'd16971, 16'd18033, 16'd19183, 16'd20434, 16'd21804, 16'd23314, 16'd24991,
      16'd26868, 16'd28986},
    '{16'd0, 16'd1124, 16'd2169, 16'd3150, 16'd4081, 16'd4970, 16'd5828, 16'd6662,
      16'd7478, 16'd8282, 16'd9081, 16'd9879, 16'd10680, 16'd11490, 16'd12313,
      16'd13153, 16'd14016, 16'd14907, 16'd15831, 16'd16793, 16'd17800, 16'd18860,
      16'd19979, 16'd21167, 16'd22434, 16'd23793, 16'd25256, 16'd26841, 16'd28567,
      16'd30457, 16'd32541, 16'd34854}
  };

  // first recommended code of each of the three ranges
  localparam logic [6:0] REC_START [4][3] = '{
    '{7'd5, 7'd55, 7'd87}, '{7'd3, 7'd54, 7'd85},
    '{7'd4, 7'd54, 7'd85}, '{7'd4, 7'd54, 7'd85}
  };

  function automatic logic [2:0] rs_num(input logic [2:0] sel);
    logic [2:0] r;
    unique case (sel)
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd5;
      3'd4:    r = 3'd5;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rs_den(input logic [2:0] sel);
    logic [1:0] r;
    unique case (sel)
      3'd3:    r = 2'd3;
      3'd4:    r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/motor_current_limit_codec_unit.sv
// current limit codec: measure, decode and encode over one shared divider
//
// channel  | handshake             | payload
// in       | in_valid / in_ready   | operation, limit_code, target_ma, sense_reading, motor_duty
// out      | out_valid / out_ready | current_ma, code_out
// cfg      | cfg_we                | cfg_index, cfg_data
//
// one evaluation runs prep with the multiply, load, 34 steps of the restoring divider,
// which all evaluations share, and the compare; prep goes straight to the compare at zero duty
// measure and decode run one evaluation each, encode up to 50 evaluations
// in_ready is high only while idle; a result waits in the output register
// rst clears the sequencer, the output valid and the configuration registers
`include "assert_macros.svh"

module motor_current_limit_codec_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [15:0]        limit_code,
  input  logic [31:0]        target_ma,
  input  logic [15:0]        sense_reading,
  input  logic signed [15:0] motor_duty,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        current_ma,
  output logic [6:0]         code_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_LOAD, S_DIV, S_EVAL, S_DONE
  } state_t;

  state_t state;
  logic [2:0]  product_select;
  logic [15:0] offset_calibration;
  logic [15:0] scale_calibration;

  mclc_pkg::op_t op;
  logic [31:0] target;
  logic [15:0] m_raw;
  logic [1:0]  m_dac;
  logic [16:0] m_mag;
  logic [31:0] prod;
  logic [mclc_pkg::DVD_W-1:0] dvd;
  logic [mclc_pkg::DVS_W-1:0] rem;
  logic [mclc_pkg::DVS_W-1:0] dvs;
  logic [5:0]  cnt;
  logic [6:0]  c;
  logic [6:0]  best;
  logic [31:0] found;
  logic [31:0] res_ma;
  logic [6:0]  res_code;

  logic        known;
  logic [1:0]  p;
  logic [15:0] offset_eff;
  logic [15:0] scale_eff;
  logic [1:0]  shift;
  logic [15:0] shifted;
  logic [15:0] cur;
  logic [16:0] duty_mag;
  logic [6:0]  dec_code;
  logic [6:0]  c_next;
  logic [mclc_pkg::DVS_W:0]   rem_sh;
  logic        sub_ok;
  logic [31:0] q_sat;

  assign known      = (product_select >= 3'd1) && (product_select <= 3'd4);
  assign p          = 2'(product_select - 3'd1);
  assign offset_eff = mclc_pkg::BASE_OFFSET + offset_calibration;
  assign scale_eff  = mclc_pkg::BASE_SCALE + scale_calibration;
  assign shift      = 2'd2 - m_dac;
  assign shifted    = m_raw >> shift;
  assign cur        = (offset_eff > shifted) ? 16'd0 : shifted - offset_eff;
  assign duty_mag   = motor_duty[15] ? 17'(17'h10000 - {1'b0, motor_duty})
                                     : {1'b0, motor_duty};
  assign dec_code   = (limit_code[7:0] > {1'b0, mclc_pkg::MAX_CODE}) ? 7'd0
                                                                     : limit_code[6:0];
  assign rem_sh     = {rem, dvd[mclc_pkg::DVD_W-1]};
  assign sub_ok     = rem_sh >= {1'b0, dvs};
  assign q_sat      = (dvd[mclc_pkg::DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : dvd[31:0];
  assign in_ready   = (state == S_IDLE);

  // next recommended code of the walk
  always_comb begin
    priority if (c == mclc_pkg::END_RANGE0) c_next = mclc_pkg::REC_START[p][1];
    else if (c == mclc_pkg::END_RANGE1)     c_next = mclc_pkg::REC_START[p][2];
    else                                    c_next = c + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      product_select     <= '0;
      offset_calibration <= '0;
      scale_calibration  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          2'(mclc_pkg::CFG_PRODUCT): product_select     <= cfg_data[2:0];
          2'(mclc_pkg::CFG_OFFSET):  offset_calibration <= cfg_data;
          2'(mclc_pkg::CFG_SCALE):   scale_calibration  <= cfg_data;
          default: ;
        endcase
      end
      if (out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= mclc_pkg::op_t'(operation);
            target   <= target_ma;
            res_ma   <= '0;
            res_code <= '0;
            best     <= '0;
            found    <= '0;
            unique case (mclc_pkg::op_t'(operation))
              mclc_pkg::OP_MEASURE: begin
                m_raw <= sense_reading;
                m_dac <= limit_code[6:5];
                m_mag <= duty_mag;
                state <= S_PREP;
              end
              mclc_pkg::OP_DECODE: begin
                m_raw <= mclc_pkg::VILIM_ROM[p][dec_code[4:0]];
                m_dac <= dec_code[6:5];
                m_mag <= mclc_pkg::DECODE_DUTY;
                state <= known ? S_PREP : S_DONE;
              end
              mclc_pkg::OP_ENCODE: begin
                // code 0 always decodes to zero, so the walk starts after it
                c     <= mclc_pkg::REC_START[p][0];
                m_raw <= mclc_pkg::VILIM_ROM[p][mclc_pkg::REC_START[p][0][4:0]];
                m_dac <= mclc_pkg::REC_START[p][0][6:5];
                m_mag <= mclc_pkg::DECODE_DUTY;
                state <= known ? S_PREP : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_PREP: begin
          if (m_mag == '0) begin
            dvd   <= '0;
            state <= S_EVAL;
          end else begin
            prod  <= cur * scale_eff;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          dvd   <= {2'b0, prod} * mclc_pkg::DVD_W'(mclc_pkg::rs_den(product_select));
          dvs   <= mclc_pkg::DVS_W'(m_mag) * mclc_pkg::DVS_W'(mclc_pkg::rs_num(product_select));
          rem   <= '0;
          cnt   <= 6'(mclc_pkg::DVD_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= sub_ok ? mclc_pkg::DVS_W'(rem_sh - {1'b0, dvs})
                          : rem_sh[mclc_pkg::DVS_W-1:0];
          dvd   <= {dvd[mclc_pkg::DVD_W-2:0], sub_ok};
          cnt   <= cnt - 6'd1;
          if (cnt == '0) state <= S_EVAL;
        end
        S_EVAL: begin
          if (op != mclc_pkg::OP_ENCODE) begin
            res_ma <= q_sat;
            state  <= S_DONE;
          end else if (q_sat > target) begin
            res_code <= best;
            state    <= S_DONE;
          end else begin
            if (q_sat > found) begin
              best  <= c;
              found <= q_sat;
            end
            if (c == mclc_pkg::MAX_CODE) begin
              res_code <= (q_sat > found) ? c : best;
              state    <= S_DONE;
            end else begin
              c     <= c_next;
              m_raw <= mclc_pkg::VILIM_ROM[p][c_next[4:0]];
              m_dac <= c_next[6:5];
              state <= S_PREP;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            current_ma <= res_ma;
            code_out   <= res_code;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MCL_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)
  `MCL_ASSERT(a_div_nonzero, clk, rst, state == S_DIV |-> dvs != '0)
  `MCL_ASSERT(a_one_field, clk, rst, out_valid && code_out != '0 |-> current_ma == '0)
  `MCL_ASSERT(a_code_range, clk, rst, out_valid |-> code_out <= mclc_pkg::MAX_CODE)

endmodule

>>> dv/tb_top.sv
// testbench for the motor current limit codec: random and directed words, scoreboard
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        code;
    logic [31:0]        target;
    logic [15:0]        raw;
    logic signed [15:0] duty;
  } req_t;

  typedef struct packed {
    logic [31:0] ma;
    logic [6:0]  cout;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic [15:0] limit_code = '0;
  logic [31:0] target_ma = '0;
  logic [15:0] sense_reading = '0;
  logic signed [15:0] motor_duty = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] current_ma;
  logic [6:0] code_out;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  motor_current_limit_codec_unit u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model copy of the configuration
  logic [2:0]  m_prod = '0;
  logic [15:0] m_ofs = '0;
  logic [15:0] m_scl = '0;

  req_t pending_words[$];
  res_t expected_res[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int idle_cycles = 0;
  bit stall_long = 1'b0;
  bit drain_hold = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] calc_current(logic [15:0] raw, logic [15:0] code,
                                               logic [15:0] duty);
    logic [15:0] ofs, scl, cur, mag;
    logic [1:0] shamt;
    logic [63:0] num, den, q;
    logic [2:0] rn;
    logic [1:0] rd;
    if (duty == 16'd0) return 32'd0;
    ofs = mclc_pkg::BASE_OFFSET + m_ofs;
    scl = mclc_pkg::BASE_SCALE + m_scl;
    shamt = 2'd2 - code[6:5];
    cur = raw >> shamt;
    cur = (ofs > cur) ? 16'd0 : cur - ofs;
    mag = duty[15] ? 16'(17'h10000 - duty) : duty;
    case (m_prod)
      3'd2: begin rn = 3'd2; rd = 2'd1; end
      3'd3: begin rn = 3'd5; rd = 2'd3; end
      3'd4: begin rn = 3'd5; rd = 2'd2; end
      default: begin rn = 3'd1; rd = 2'd1; end
    endcase
    num = 64'(cur) * 64'(scl) * 64'(rd);
    den = 64'(mag) * 64'(rn);
    q = num / den;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] limit_to_ma(logic [15:0] code);
    logic [7:0] c;
    if (m_prod < 3'd1 || m_prod > 3'd4) return 32'd0;
    c = code[7:0];
    if (c > 8'd95) c = 8'd0;
    return calc_current(mclc_pkg::VILIM_ROM[m_prod - 1][c[4:0]], {8'd0, c}, 16'd600);
  endfunction

  function automatic logic [6:0] best_code(logic [31:0] target);
    logic [31:0] found, ma;
    logic [6:0] best, ends [3];
    int p;
    best = '0;
    ends[0] = mclc_pkg::END_RANGE0; ends[1] = mclc_pkg::END_RANGE1;
    ends[2] = mclc_pkg::MAX_CODE;
    if (m_prod < 3'd1 || m_prod > 3'd4) return 7'd0;
    p = m_prod - 1;
    found = limit_to_ma(16'd0);
    if (found > target) return 7'd0;
    for (int r = 0; r < 3; r++)
      for (int c = mclc_pkg::REC_START[p][r]; c <= ends[r]; c++) begin
        ma = limit_to_ma(16'(c));
        if (ma > target) return best;
        if (ma > found) begin
          best = 7'(c);
          found = ma;
        end
      end
    return best;
  endfunction

  function automatic res_t codec_result(req_t w);
    res_t r;
    r = '0;
    case (w.op)
      mclc_pkg::OP_DECODE:  r.ma = limit_to_ma(w.code);
      mclc_pkg::OP_ENCODE:  r.cout = best_code(w.target);
      mclc_pkg::OP_MEASURE: r.ma = calc_current(w.raw, w.code, w.duty);
      default:              r = '0;
    endcase
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_res.push_back(codec_result({operation, limit_code, target_ma,
                                             sense_reading, motor_duty}));
        n_sent++;
        send_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if ((!in_valid || in_ready) && !drain_hold) begin
        if (send_gap > 0 || pending_words.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          req_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          operation <= w.op;
          limit_code <= w.code;
          target_ma <= w.target;
          sense_reading <= w.raw;
          motor_duty <= w.duty;
        end
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  int recv_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        res_t e;
        n_recv++;
        if (expected_res.size() == 0) begin
          $error("result with no word outstanding");
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (current_ma !== e.ma) begin
            $error("current_ma expected %0d actual %0d", e.ma, current_ma);
            errors++;
          end
          if (code_out !== e.cout) begin
            $error("code_out expected %0d actual %0d", e.cout, code_out);
            errors++;
          end
        end
        recv_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (stall_long && hold_cnt < 400) begin
        hold_cnt++;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst ||
        (pending_words.size() == 0 && !stim_done && !in_valid &&
         expected_res.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      2'(mclc_pkg::CFG_PRODUCT): m_prod = val[2:0];
      2'(mclc_pkg::CFG_OFFSET):  m_ofs = val;
      2'(mclc_pkg::CFG_SCALE):   m_scl = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic req_t rand_word();
    req_t w;
    w.op = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 7) != 0 && w.op == mclc_pkg::OP_NONE) w.op = mclc_pkg::OP_MEASURE;
    w.code = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
    case ($urandom_range(0, 3))
      0: w.target = $urandom;
      1: w.target = 32'($urandom_range(0, 60000));
      2: w.target = 32'($urandom_range(0, 5000));
      default: w.target = 32'($urandom_range(0, 1000000));
    endcase
    w.raw = 16'($urandom);
    w.duty = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom);
    if ($urandom_range(0, 2) == 0) w.duty = 16'($urandom_range(1, 700));
    return w;
  endfunction

  initial begin
    logic [15:0] ofs_set [4];
    logic [15:0] scl_set [4];
    ofs_set = '{16'd0, 16'h8000, 16'h7FFF, 16'hFCE0};
    scl_set = '{16'd0, 16'h7FFF, 16'h8000, 16'hF8AD};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: product 1, edge codes, duty extremes
    write_reg(2'(mclc_pkg::CFG_PRODUCT), 16'd1);
    pending_words.push_back('{mclc_pkg::OP_DECODE, 16'd95, 32'd0, 16'd0, 16'sd0});
    pending_words.push_back('{mclc_pkg::OP_DECODE, 16'd96, 32'd0, 16'd0, 16'sd0});
    pending_words.push_back('{mclc_pkg::OP_DECODE, 16'hFF5F, 32'd0, 16'd0, 16'sd0});
    pending_words.push_back('{mclc_pkg::OP_ENCODE, 16'd0, 32'd0, 16'd0, 16'sd0});
    pending_words.push_back('{mclc_pkg::OP_ENCODE, 16'd0, 32'hFFFF_FFFF, 16'd0, 16'sd0});
    pending_words.push_back('{mclc_pkg::OP_ENCODE, 16'd0, 32'd3000, 16'd0, 16'sd0});
    pending_words.push_back('{mclc_pkg::OP_MEASURE, 16'd0, 32'd0, 16'hFFFF, 16'sd0});
    pending_words.push_back('{mclc_pkg::OP_MEASURE, 16'h0060, 32'd0, 16'hFFFF, 16'sh8000});
    pending_words.push_back('{mclc_pkg::OP_MEASURE, 16'h0040, 32'd0, 16'hFFFF, 16'sd1});
    pending_words.push_back('{mclc_pkg::OP_MEASURE, 16'h0020, 32'd0, 16'd0, 16'sh7FFF});
    pending_words.push_back('{mclc_pkg::OP_MEASURE, 16'hFFFF, 32'd0, 16'd100, 16'shFFFF});
    pending_words.push_back('{mclc_pkg::OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                              16'shFFFF});
    wait_drained();
    for (int p = 0; p < 8; p++) begin
      write_reg(2'(mclc_pkg::CFG_PRODUCT), 16'(p));
      write_reg(2'(mclc_pkg::CFG_OFFSET), ofs_set[p % 4]);
      write_reg(2'(mclc_pkg::CFG_SCALE), scl_set[(p / 2) % 4]);
      for (int i = 0; i < 38; i++) pending_words.push_back(rand_word());
      // receiver holds off while the sender keeps offering
      if (p == 2) stall_long = 1'b1;
      while (pending_words.size() != 0) @(posedge clk);
      // sender pauses until everything has come back
      if (p == 4) begin
        drain_hold = 1'b1;
        while (expected_res.size() != 0 || in_valid) @(posedge clk);
        drain_hold = 1'b0;
      end
      wait_drained();
    end
    stim_done = 1'b1;
    repeat (100) @(posedge clk);
    $display("sent %0d words, checked %0d results over all products and calibration extremes",
             n_sent, n_recv);
    if (errors == 0 && expected_res.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
